### hw/rtl/bctc_pkg.sv
// Shared types and codes for the block cache tag controller.
package bctc_pkg;

   // Request functions
   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_MARK  = 2'd1;
   localparam logic [1:0] FUNC_FLUSH = 2'd2;

   // Result status codes
   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_WB_FAIL    = 2'd1;
   localparam logic [1:0] STAT_FETCH_FAIL = 2'd2;
   localparam logic [1:0] STAT_NOT_CACHED = 2'd3;

   // A flush reports at most this many entries; only this many have fail bits
   localparam logic [4:0] FLUSH_MAX = 5'd16;
   localparam int         FAIL_BITS = 16;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] lba;
      logic [3:0]  buffer_index;
      logic        writeback_fails;
      logic        fetch_fails;
      logic [15:0] flush_fail_mask;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  entry_index;
      logic        was_hit;
      logic        writeback_valid;
      logic [31:0] writeback_lba;
      logic        fetch_valid;
      logic [31:0] fetch_lba;
      logic        flush_failed;
      logic [31:0] hit_count;
      logic [31:0] miss_count;
      logic        last;
   } rsp_item_type;

   // Sequencer to tag compare unit
   typedef struct packed {
      logic clear;
      logic step;
   } scan_ctrl_type;

   // Tag compare unit to sequencer
   typedef struct packed {
      logic hit;
      logic vic_wb;
   } scan_stat_type;

endpackage

### hw/rtl/bctc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bctc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bctc_scan.sv
// Tag compare unit: one entry per step, tracks the first hit and the victim.
module bctc_scan #(
   parameter int ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bctc_pkg::scan_ctrl_type    ctrl,
   input  logic [$clog2(ENTRIES)-1:0] idx,
   input  logic                       ent_valid,
   input  logic                       ent_dirty,
   input  logic [31:0]                sector,
   input  logic [31:0]                age,
   input  logic [31:0]                lba,
   output bctc_pkg::scan_stat_type    stat,
   output logic [$clog2(ENTRIES)-1:0] hit_idx,
   output logic [$clog2(ENTRIES)-1:0] vic_idx,
   output logic [31:0]                vic_sector
);

   localparam int IDX_W = $clog2(ENTRIES);

   logic             hit_ff, hit_in;
   logic             free_ff, free_in;
   logic             have_ff, have_in;
   logic             vic_wb_ff, vic_wb_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0] vic_idx_ff, vic_idx_in;
   logic [31:0]      best_age_ff, best_age_in;
   logic [31:0]      vic_sector_ff, vic_sector_in;
   logic             match;
   logic             older;

   // the shared comparators
   assign match = ent_valid && (sector == lba);
   assign older = !have_ff || (age < best_age_ff);

   always_comb begin
      hit_in        = hit_ff;
      free_in       = free_ff;
      have_in       = have_ff;
      vic_wb_in     = vic_wb_ff;
      hit_idx_in    = hit_idx_ff;
      vic_idx_in    = vic_idx_ff;
      best_age_in   = best_age_ff;
      vic_sector_in = vic_sector_ff;
      if (ctrl.clear) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
         have_in = 1'b0;
      end else if (ctrl.step) begin
         // first matching entry wins
         if (match && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = idx;
         end
         // first free entry, else oldest stamp with lowest index on ties
         if (!free_ff) begin
            if (!ent_valid) begin
               free_in    = 1'b1;
               vic_idx_in = idx;
               vic_wb_in  = 1'b0;
            end else if (older) begin
               have_in       = 1'b1;
               vic_idx_in    = idx;
               best_age_in   = age;
               vic_sector_in = sector;
               vic_wb_in     = ent_dirty;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff    <= 1'b0;
         free_ff   <= 1'b0;
         have_ff   <= 1'b0;
         vic_wb_ff <= 1'b0;
      end else begin
         hit_ff    <= hit_in;
         free_ff   <= free_in;
         have_ff   <= have_in;
         vic_wb_ff <= vic_wb_in;
      end
      hit_idx_ff    <= hit_idx_in;
      vic_idx_ff    <= vic_idx_in;
      best_age_ff   <= best_age_in;
      vic_sector_ff <= vic_sector_in;
   end

   assign stat.hit    = hit_ff;
   assign stat.vic_wb = vic_wb_ff;
   assign hit_idx     = hit_idx_ff;
   assign vic_idx     = vic_idx_ff;
   assign vic_sector  = vic_sector_ff;

endmodule

### hw/rtl/block_cache_tag_controller_unit.sv
// Block cache tag controller top level: sequencer, tag state, counters, output.
//
// Requests enter on req_valid/req_ready with req_item; results leave on
// rsp_valid/rsp_ready with rsp_item. One request is worked on at a time and
// req_ready is high only while the sequencer is idle.
// A read walks every entry through one tag compare unit, one entry per cycle
// fed from the sector and age RAMs, then a drain and a finish state before the
// result goes to the output register. A mark-dirty is answered from its own
// state. A flush walks the valid and dirty bits, skipping clean entries and
// passing a capture state for each dirty entry, and gives one item per dirty
// entry (at most 16), the last one flagged; with nothing dirty it gives a
// single empty item. Unknown functions give no item. Results sit in one
// output register; while the receiver stalls the sequencer holds before
// emitting, and a new request may be accepted once the last item is in it.
// Reset (synchronous, active high) clears valid and dirty bits, the age
// stamp and the hit and miss counters at once; no clearing pass is needed,
// since sector and age RAM words are only read for valid entries.
module block_cache_tag_controller_unit #(
   parameter int ENTRIES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bctc_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bctc_pkg::rsp_item_type rsp_item
);

   localparam int               IDX_W    = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DRAIN  = 3'd2;
   localparam logic [2:0] S_RD_FIN = 3'd3;
   localparam logic [2:0] S_MARK   = 3'd4;
   localparam logic [2:0] S_FL_RD  = 3'd5;
   localparam logic [2:0] S_FL_CAP = 3'd6;
   localparam logic [2:0] S_FL_END = 3'd7;

   logic [2:0]             state_ff, state_in;
   bctc_pkg::req_item_type req_ff, req_in;
   logic [IDX_W-1:0]       cnt_ff, cnt_in;
   logic                   step_ff;
   logic [IDX_W-1:0]       step_idx_ff;
   logic [ENTRIES-1:0]     valid_ff, valid_in;
   logic [ENTRIES-1:0]     dirty_ff, dirty_in;
   logic [31:0]            age_ff, age_in;
   logic [31:0]            hits_ff, hits_in;
   logic [31:0]            misses_ff, misses_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   bctc_pkg::rsp_item_type rsp_ff, rsp_in;
   logic                   pend_valid_ff, pend_valid_in;
   bctc_pkg::rsp_item_type pend_ff, pend_in;
   logic [4:0]             fl_n_ff, fl_n_in;
   logic                   fl_fail_ff, fl_fail_in;

   logic                   slot_free;
   logic                   rsp_emit;
   bctc_pkg::rsp_item_type rsp_new;
   bctc_pkg::rsp_item_type base;
   logic                   age_we;
   logic [IDX_W-1:0]       age_waddr;
   logic                   sec_we;
   logic [31:0]            sec_rdata;
   logic [31:0]            age_rdata;
   logic [IDX_W-1:0]       mark_idx;
   logic [3:0]             fl_bit;
   logic                   fl_fails;

   bctc_pkg::scan_ctrl_type scan_ctrl;
   bctc_pkg::scan_stat_type scan_stat;
   logic [IDX_W-1:0]        hit_idx;
   logic [IDX_W-1:0]        vic_idx;
   logic [31:0]             vic_sector;

   // tag storage
   bctc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_sector_ram (
      .clock   (clock),
      .wr_en   (sec_we),
      .wr_addr (vic_idx),
      .wr_data (req_ff.lba),
      .rd_addr (cnt_ff),
      .rd_data (sec_rdata)
   );

   bctc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_age_ram (
      .clock   (clock),
      .wr_en   (age_we),
      .wr_addr (age_waddr),
      .wr_data (age_in),
      .rd_addr (cnt_ff),
      .rd_data (age_rdata)
   );

   // shared compare unit for the read walk
   assign scan_ctrl.clear = (state_ff == S_IDLE) && req_valid
                            && (req_item.func == bctc_pkg::FUNC_READ);
   assign scan_ctrl.step  = step_ff;

   bctc_scan #(.ENTRIES(ENTRIES)) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (scan_ctrl),
      .idx        (step_idx_ff),
      .ent_valid  (valid_ff[step_idx_ff]),
      .ent_dirty  (dirty_ff[step_idx_ff]),
      .sector     (sec_rdata),
      .age        (age_rdata),
      .lba        (req_ff.lba),
      .stat       (scan_stat),
      .hit_idx    (hit_idx),
      .vic_idx    (vic_idx),
      .vic_sector (vic_sector)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign mark_idx  = IDX_W'(req_ff.buffer_index);
   assign fl_bit    = 4'(cnt_ff);
   assign fl_fails  = (32'(cnt_ff) < bctc_pkg::FAIL_BITS)
                      && req_ff.flush_fail_mask[fl_bit];

   always_comb begin
      base            = '0;
      base.hit_count  = hits_ff;
      base.miss_count = misses_ff;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      cnt_in        = cnt_ff;
      valid_in      = valid_ff;
      dirty_in      = dirty_ff;
      age_in        = age_ff;
      hits_in       = hits_ff;
      misses_in     = misses_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      fl_n_in       = fl_n_ff;
      fl_fail_in    = fl_fail_ff;
      rsp_emit      = 1'b0;
      rsp_new       = base;
      age_we        = 1'b0;
      age_waddr     = vic_idx;
      sec_we        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_item;
               cnt_in = '0;
               case (req_item.func)
                  bctc_pkg::FUNC_READ: state_in = S_SCAN;
                  bctc_pkg::FUNC_MARK: state_in = S_MARK;
                  bctc_pkg::FUNC_FLUSH: begin
                     fl_n_in       = '0;
                     fl_fail_in    = 1'b0;
                     pend_valid_in = 1'b0;
                     state_in      = S_FL_RD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_SCAN: begin
            if (cnt_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         S_DRAIN: state_in = S_RD_FIN;

         S_RD_FIN: begin
            if (slot_free) begin
               rsp_emit     = 1'b1;
               rsp_new.last = 1'b1;
               state_in     = S_IDLE;
               if (scan_stat.hit) begin
                  hits_in             = hits_ff + 32'd1;
                  age_in              = age_ff + 32'd1;
                  age_we              = 1'b1;
                  age_waddr           = hit_idx;
                  rsp_new.entry_index = 4'(hit_idx);
                  rsp_new.was_hit     = 1'b1;
                  rsp_new.hit_count   = hits_ff + 32'd1;
               end else begin
                  misses_in           = misses_ff + 32'd1;
                  rsp_new.miss_count  = misses_ff + 32'd1;
                  rsp_new.entry_index = 4'(vic_idx);
                  if (scan_stat.vic_wb) begin
                     rsp_new.writeback_valid = 1'b1;
                     rsp_new.writeback_lba   = vic_sector;
                  end
                  if (scan_stat.vic_wb && req_ff.writeback_fails) begin
                     rsp_new.status = bctc_pkg::STAT_WB_FAIL;
                  end else begin
                     dirty_in[vic_idx]   = 1'b0;
                     rsp_new.fetch_valid = 1'b1;
                     rsp_new.fetch_lba   = req_ff.lba;
                     if (req_ff.fetch_fails) begin
                        valid_in[vic_idx] = 1'b0;
                        rsp_new.status    = bctc_pkg::STAT_FETCH_FAIL;
                     end else begin
                        sec_we            = 1'b1;
                        age_in            = age_ff + 32'd1;
                        age_we            = 1'b1;
                        valid_in[vic_idx] = 1'b1;
                     end
                  end
               end
            end
         end

         S_MARK: begin
            if (slot_free) begin
               rsp_emit            = 1'b1;
               rsp_new.last        = 1'b1;
               rsp_new.entry_index = req_ff.buffer_index;
               state_in            = S_IDLE;
               if ((32'(req_ff.buffer_index) >= ENTRIES) || !valid_ff[mark_idx]) begin
                  rsp_new.status = bctc_pkg::STAT_NOT_CACHED;
               end else begin
                  dirty_in[mark_idx] = 1'b1;
                  age_in             = age_ff + 32'd1;
                  age_we             = 1'b1;
                  age_waddr          = mark_idx;
               end
            end
         end

         // skip clean entries, fetch the sector of dirty ones
         S_FL_RD: begin
            if (valid_ff[cnt_ff] && dirty_ff[cnt_ff]) begin
               state_in = S_FL_CAP;
            end else if (cnt_ff == LAST_IDX) begin
               state_in = S_FL_END;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // the previous dirty entry is pending until we know it is not the last
         S_FL_CAP: begin
            if (!pend_valid_ff || slot_free) begin
               if (pend_valid_ff) begin
                  rsp_emit = 1'b1;
                  rsp_new  = pend_ff;
               end
               pend_in                 = base;
               pend_in.entry_index     = 4'(cnt_ff);
               pend_in.writeback_valid = 1'b1;
               pend_in.writeback_lba   = sec_rdata;
               if (fl_fails) begin
                  pend_in.status = bctc_pkg::STAT_WB_FAIL;
                  fl_fail_in     = 1'b1;
               end else begin
                  dirty_in[cnt_ff] = 1'b0;
               end
               pend_valid_in = 1'b1;
               fl_n_in       = fl_n_ff + 5'd1;
               if ((fl_n_ff + 5'd1 == bctc_pkg::FLUSH_MAX) || (cnt_ff == LAST_IDX)) begin
                  state_in = S_FL_END;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = S_FL_RD;
               end
            end
         end

         S_FL_END: begin
            if (slot_free) begin
               rsp_emit = 1'b1;
               if (pend_valid_ff) begin
                  rsp_new              = pend_ff;
                  rsp_new.flush_failed = fl_fail_ff;
               end
               rsp_new.last  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_new;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         step_ff       <= 1'b0;
         valid_ff      <= '0;
         dirty_ff      <= '0;
         age_ff        <= '0;
         hits_ff       <= '0;
         misses_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         fl_n_ff       <= '0;
         fl_fail_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= (state_ff == S_SCAN);
         valid_ff      <= valid_in;
         dirty_ff      <= dirty_in;
         age_ff        <= age_in;
         hits_ff       <= hits_in;
         misses_ff     <= misses_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         fl_n_ff       <= fl_n_in;
         fl_fail_ff    <= fl_fail_in;
      end
      req_ff      <= req_in;
      cnt_ff      <= cnt_in;
      step_idx_ff <= cnt_ff;
      rsp_ff      <= rsp_in;
      pend_ff     <= pend_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // a result that is not the last one means a flush is still running
   a_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |-> state_ff != S_IDLE)
      else $error("non-final result while sequencer idle");

   // a reported hit always advances the hit counter by one
   a_hit_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_emit && rsp_new.was_hit |=> hits_ff == $past(hits_ff) + 32'd1)
      else $error("hit counter did not advance on hit");

   // a flush never reports more entries than its limit
   a_flush_limit: assert property (@(posedge clock) disable iff (reset)
      fl_n_ff <= bctc_pkg::FLUSH_MAX)
      else $error("flush result count over limit");

   // the flush failure summary only rides on the final result
   a_flush_fail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.flush_failed |-> rsp_ff.last)
      else $error("flush_failed on a non-final result");

endmodule
